FILE: hw/rtl/mvna_pkg.sv
// package: table size, item modes, accumulator limits and sequencer states of the vertex normal accumulator
package mvna_pkg;

    localparam int VERTEX_COUNT = 64;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ACC_MIN = -24'sh800000;
    localparam logic [14:0]        ONE_Q14 = 15'd16384;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_PCAP,
        ST_DIFF,
        ST_CROSS,
        ST_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_UREAD,
        ST_UWRITE,
        ST_RREAD,
        ST_RCAP,
        ST_OUT
    } t_state;

endpackage

FILE: hw/rtl/mvna_if.sv
// channel interfaces: input item and result item with valid/ready handshake
interface mvna_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [5:0]  corner_a;
    logic [5:0]  corner_b;
    logic [5:0]  corner_c;

    modport source (output valid, mode, vertex_index, coord_x, coord_y, coord_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, mode, vertex_index, coord_x, coord_y, coord_z,
                    corner_a, corner_b, corner_c, output ready);
endinterface

interface mvna_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  read_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        normal_undefined;

    modport source (output valid, read_index, normal_x, normal_y, normal_z,
                    normal_undefined, input ready);
    modport sink   (input valid, read_index, normal_x, normal_y, normal_z,
                    normal_undefined, output ready);
endinterface

FILE: hw/rtl/mesh_vertex_normal_accumulator.sv
// top level: vertex table, normal accumulators and shared-multiplier sequencer
//
//  channel | dir | payload                                              | transfer when
//  i_in    | in  | mode, vertex_index, coord_x/y/z, corner_a/b/c        | valid & ready
//  o_out   | out | read_index, normal_x/y/z, normal_undefined           | valid & ready
//
// load: written in the accept cycle. read: accept, sum fetch, magnitudes, shift check,
// squares, root steps, a divide per component, then the result; a zero sum skips to it.
// triangle: accept, position fetch, differences, cross product, the same unit-length pass
// with its shift steps, then each corner's accumulator update; a degenerate face ends at MAG.
// one 32x32 multiplier serves cross product and squares; bit-pair root, restoring divider.
// i_in.ready is high only in idle; a result waits in the output register while the next
// item is taken; a finished read stalls until that register is free.
// synchronous active-low reset clears the sequencer and output valid; tables need a load.
module mesh_vertex_normal_accumulator (
    input  logic i_clk,
    input  logic i_rst_n,
    mvna_in_if.sink    i_in,
    mvna_out_if.source o_out
);

    localparam int AW = mvna_pkg::IDX_W;

    mvna_pkg::t_state r_state, n_state;

    // memories
    logic [47:0] r_pos_mem [mvna_pkg::VERTEX_COUNT];
    logic [71:0] r_sum_mem [mvna_pkg::VERTEX_COUNT];
    logic [47:0] r_pos_q;
    logic [71:0] r_sum_q;
    logic [AW-1:0] pos_raddr, sum_raddr, sum_waddr;
    logic          pos_we, sum_we;
    logic [71:0]   sum_wdata;

    // item and working registers
    logic [5:0]  r_vi;
    logic [5:0]  r_corner [3];
    logic        r_is_read;
    logic signed [15:0] r_p1 [3], r_p2 [3], r_p3 [3];
    logic signed [16:0] r_d1 [3], r_d2 [3];
    logic signed [35:0] r_c [3];
    logic [35:0] r_mag [3];
    logic        r_neg [3];
    logic signed [63:0] r_prod;
    logic signed [31:0] mul_a, mul_b;
    logic [61:0] r_sq;
    logic [61:0] r_n;
    logic [62:0] r_r, r_bit;
    logic [45:0] r_rem, r_dsh;
    logic [14:0] r_q;
    logic [2:0]  r_k;
    logic [3:0]  r_cnt;
    logic [1:0]  r_comp;
    logic signed [15:0] r_nrm [3];
    logic        r_undef;

    // output register
    logic        r_out_valid;
    logic [5:0]  r_out_idx;
    logic signed [15:0] r_out_n [3];
    logic        r_out_undef;

    logic in_xfer, out_load, all_zero, need_shift, tri_ok, vi_ok;
    logic [62:0] sqrt_sum;
    logic        sqrt_ge, div_ge;
    logic [14:0] q_next, q_clamp;
    logic signed [23:0] sum_old [3];

    function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                   input logic signed [15:0] b);
        logic signed [24:0] s;
        s = 25'({a[23], a}) + 25'({{9{b[15]}}, b});
        if (s[24] != s[23]) begin
            return s[24] ? mvna_pkg::ACC_MIN : mvna_pkg::ACC_MAX;
        end
        return s[23:0];
    endfunction

    assign in_xfer  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == mvna_pkg::ST_IDLE);
    assign out_load = (r_state == mvna_pkg::ST_OUT) && (!r_out_valid || o_out.ready);

    assign vi_ok  = {1'b0, i_in.vertex_index} < 7'(mvna_pkg::VERTEX_COUNT);
    assign tri_ok = ({1'b0, i_in.corner_a} < 7'(mvna_pkg::VERTEX_COUNT))
                 && ({1'b0, i_in.corner_b} < 7'(mvna_pkg::VERTEX_COUNT))
                 && ({1'b0, i_in.corner_c} < 7'(mvna_pkg::VERTEX_COUNT));

    assign all_zero   = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    assign need_shift = (r_mag[0][35:30] != '0) || (r_mag[1][35:30] != '0)
                     || (r_mag[2][35:30] != '0);

    // one bit-pair step of the integer square root
    assign sqrt_sum = r_r + r_bit;
    assign sqrt_ge  = {1'b0, r_n} >= sqrt_sum;

    // one restoring divide step, quotient is at most one in Q1.14
    assign div_ge  = r_rem >= r_dsh;
    assign q_next  = {r_q[13:0], div_ge};
    assign q_clamp = (q_next > mvna_pkg::ONE_Q14) ? mvna_pkg::ONE_Q14 : q_next;

    assign sum_old[0] = r_sum_q[23:0];
    assign sum_old[1] = r_sum_q[47:24];
    assign sum_old[2] = r_sum_q[71:48];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == mvna_pkg::ST_CROSS) begin
            case (r_k)
                3'd0: begin mul_a = 32'(r_d1[1]); mul_b = 32'(r_d2[2]); end
                3'd1: begin mul_a = 32'(r_d1[2]); mul_b = 32'(r_d2[1]); end
                3'd2: begin mul_a = 32'(r_d1[2]); mul_b = 32'(r_d2[0]); end
                3'd3: begin mul_a = 32'(r_d1[0]); mul_b = 32'(r_d2[2]); end
                3'd4: begin mul_a = 32'(r_d1[0]); mul_b = 32'(r_d2[1]); end
                3'd5: begin mul_a = 32'(r_d1[1]); mul_b = 32'(r_d2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == mvna_pkg::ST_SQ && r_k < 3'd3) begin
            mul_a = {2'b0, r_mag[r_k[1:0]][29:0]};
            mul_b = {2'b0, r_mag[r_k[1:0]][29:0]};
        end
    end

    // memory port control
    always_comb begin
        pos_raddr = r_corner[0][AW-1:0];
        pos_we    = 1'b0;
        sum_raddr = r_corner[r_comp][AW-1:0];
        sum_we    = 1'b0;
        sum_waddr = r_corner[r_comp][AW-1:0];
        sum_wdata = {sat_add(sum_old[2], r_nrm[2]), sat_add(sum_old[1], r_nrm[1]),
                     sat_add(sum_old[0], r_nrm[0])};
        case (r_state)
            mvna_pkg::ST_IDLE: begin
                if (in_xfer && i_in.mode == mvna_pkg::MODE_LOAD && vi_ok) begin
                    pos_we    = 1'b1;
                    sum_we    = 1'b1;
                    sum_waddr = i_in.vertex_index[AW-1:0];
                    sum_wdata = '0;
                end
            end
            mvna_pkg::ST_PB:     pos_raddr = r_corner[1][AW-1:0];
            mvna_pkg::ST_PC:     pos_raddr = r_corner[2][AW-1:0];
            mvna_pkg::ST_RREAD:  sum_raddr = r_vi[AW-1:0];
            mvna_pkg::ST_UWRITE: sum_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[i_in.vertex_index[AW-1:0]] <= {i_in.coord_z, i_in.coord_y, i_in.coord_x};
        end
        r_pos_q <= r_pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_q <= r_sum_mem[sum_raddr];
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvna_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mvna_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in.mode)
                        mvna_pkg::MODE_TRI:  if (tri_ok) n_state = mvna_pkg::ST_PA;
                        mvna_pkg::MODE_READ: n_state = vi_ok ? mvna_pkg::ST_RREAD
                                                             : mvna_pkg::ST_OUT;
                        default: n_state = mvna_pkg::ST_IDLE;
                    endcase
                end
            end
            mvna_pkg::ST_PA:    n_state = mvna_pkg::ST_PB;
            mvna_pkg::ST_PB:    n_state = mvna_pkg::ST_PC;
            mvna_pkg::ST_PC:    n_state = mvna_pkg::ST_PCAP;
            mvna_pkg::ST_PCAP:  n_state = mvna_pkg::ST_DIFF;
            mvna_pkg::ST_DIFF:  n_state = mvna_pkg::ST_CROSS;
            mvna_pkg::ST_CROSS: if (r_k == 3'd6) n_state = mvna_pkg::ST_MAG;
            mvna_pkg::ST_MAG: begin
                if (all_zero) begin
                    n_state = r_is_read ? mvna_pkg::ST_OUT : mvna_pkg::ST_IDLE;
                end else begin
                    n_state = mvna_pkg::ST_SHIFT;
                end
            end
            mvna_pkg::ST_SHIFT: if (!need_shift) n_state = mvna_pkg::ST_SQ;
            mvna_pkg::ST_SQ:    if (r_k == 3'd3) n_state = mvna_pkg::ST_SQRT;
            mvna_pkg::ST_SQRT:  if (r_bit[0]) n_state = mvna_pkg::ST_DINIT;
            mvna_pkg::ST_DINIT: n_state = mvna_pkg::ST_DIV;
            mvna_pkg::ST_DIV: begin
                if (r_cnt == 4'd14) begin
                    if (r_comp != 2'd2) begin
                        n_state = mvna_pkg::ST_DINIT;
                    end else begin
                        n_state = r_is_read ? mvna_pkg::ST_OUT : mvna_pkg::ST_UREAD;
                    end
                end
            end
            mvna_pkg::ST_UREAD:  n_state = mvna_pkg::ST_UWRITE;
            mvna_pkg::ST_UWRITE: if (r_comp == 2'd2) n_state = mvna_pkg::ST_IDLE;
                                 else n_state = mvna_pkg::ST_UREAD;
            mvna_pkg::ST_RREAD:  n_state = mvna_pkg::ST_RCAP;
            mvna_pkg::ST_RCAP:   n_state = mvna_pkg::ST_MAG;
            mvna_pkg::ST_OUT:    if (out_load) n_state = mvna_pkg::ST_IDLE;
            default: n_state = mvna_pkg::ST_IDLE;
        endcase
    end

    // step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_cnt  <= '0;
            r_comp <= '0;
        end else begin
            if (r_state == mvna_pkg::ST_CROSS || r_state == mvna_pkg::ST_SQ) begin
                r_k <= r_k + 3'd1;
            end else begin
                r_k <= '0;
            end
            if (r_state == mvna_pkg::ST_DIV) begin
                r_cnt <= r_cnt + 4'd1;
            end else begin
                r_cnt <= '0;
            end
            case (r_state)
                mvna_pkg::ST_SQRT: r_comp <= '0;
                mvna_pkg::ST_DIV: begin
                    if (r_cnt == 4'd14) r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                end
                mvna_pkg::ST_UWRITE: r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            mvna_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    r_vi      <= i_in.vertex_index;
                    r_corner[0] <= i_in.corner_a;
                    r_corner[1] <= i_in.corner_b;
                    r_corner[2] <= i_in.corner_c;
                    r_is_read <= (i_in.mode == mvna_pkg::MODE_READ);
                    r_undef   <= 1'b1;
                    for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
                end
            end
            mvna_pkg::ST_PB: begin
                r_p1[0] <= r_pos_q[15:0]; r_p1[1] <= r_pos_q[31:16]; r_p1[2] <= r_pos_q[47:32];
            end
            mvna_pkg::ST_PC: begin
                r_p2[0] <= r_pos_q[15:0]; r_p2[1] <= r_pos_q[31:16]; r_p2[2] <= r_pos_q[47:32];
            end
            mvna_pkg::ST_PCAP: begin
                r_p3[0] <= r_pos_q[15:0]; r_p3[1] <= r_pos_q[31:16]; r_p3[2] <= r_pos_q[47:32];
            end
            mvna_pkg::ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_d1[i] <= 17'(r_p3[i]) - 17'(r_p2[i]);
                    r_d2[i] <= 17'(r_p2[i]) - 17'(r_p1[i]);
                end
            end
            mvna_pkg::ST_CROSS: begin
                // product of step k lands in the next step, pairs form c = a*b - c*d
                if (r_k != 3'd0) begin
                    if (r_k[0]) begin
                        r_c[r_k[2:1]] <= r_prod[35:0];
                    end else begin
                        r_c[r_k[2:1] - 2'd1] <= r_c[r_k[2:1] - 2'd1] - r_prod[35:0];
                    end
                end
            end
            mvna_pkg::ST_RCAP: begin
                for (int i = 0; i < 3; i++) r_c[i] <= 36'(sum_old[i]);
            end
            mvna_pkg::ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_c[i][35];
                    r_mag[i] <= r_c[i][35] ? 36'(-r_c[i]) : 36'(r_c[i]);
                end
            end
            mvna_pkg::ST_SHIFT: begin
                if (need_shift) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end
            end
            mvna_pkg::ST_SQ: begin
                if (r_k == 3'd1) begin
                    r_sq <= r_prod[61:0];
                end else if (r_k == 3'd2) begin
                    r_sq <= r_sq + r_prod[61:0];
                end else if (r_k == 3'd3) begin
                    r_n   <= r_sq + r_prod[61:0];
                    r_r   <= '0;
                    r_bit <= 63'(1) << 62;
                end
            end
            mvna_pkg::ST_SQRT: begin
                if (sqrt_ge) begin
                    r_n <= r_n - sqrt_sum[61:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            mvna_pkg::ST_DINIT: begin
                r_rem <= {2'b0, r_mag[r_comp][29:0], 14'b0} + {16'b0, r_r[30:1]};
                r_dsh <= {1'b0, r_r[30:0], 14'b0};
                r_q   <= '0;
            end
            mvna_pkg::ST_DIV: begin
                if (div_ge) r_rem <= r_rem - r_dsh;
                r_dsh <= r_dsh >> 1;
                r_q   <= q_next;
                if (r_cnt == 4'd14) begin
                    r_nrm[r_comp] <= r_neg[r_comp] ? -16'(q_clamp) : 16'(q_clamp);
                    r_undef <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx   <= r_vi;
            r_out_n[0]  <= r_nrm[0];
            r_out_n[1]  <= r_nrm[1];
            r_out_n[2]  <= r_nrm[2];
            r_out_undef <= r_undef;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.read_index       = r_out_idx;
    assign o_out.normal_x         = r_out_n[0];
    assign o_out.normal_y         = r_out_n[1];
    assign o_out.normal_z         = r_out_n[2];
    assign o_out.normal_undefined = r_out_undef;

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == mvna_pkg::ST_OUT)
        else $error("result appeared outside the output state");
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mvna_pkg::ST_SQRT |-> $onehot(r_bit))
        else $error("square root bit lost");
    a_shift_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mvna_pkg::ST_SQ |-> !need_shift)
        else $error("magnitudes not scaled below 2^30");
`endif

endmodule

FILE: tb/mesh_vertex_normal_accumulator_tb.sv
// testbench: random and directed vertex loads, triangles and normal reads, checked
// against a behavioral copy of the vertex table and normal accumulators
module mesh_vertex_normal_accumulator_tb;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [1:0]         mode;
        logic [5:0]         vertex_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [5:0]         corner_a;
        logic [5:0]         corner_b;
        logic [5:0]         corner_c;
    } t_item;

    typedef struct {
        logic [5:0]         read_index;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               normal_undefined;
    } t_normal;

    logic i_clk;
    logic i_rst_n;

    mvna_in_if  in_ch ();
    mvna_out_if out_ch ();

    mesh_vertex_normal_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted table state
    logic signed [15:0] pos_x [mvna_pkg::VERTEX_COUNT];
    logic signed [15:0] pos_y [mvna_pkg::VERTEX_COUNT];
    logic signed [15:0] pos_z [mvna_pkg::VERTEX_COUNT];
    int                 acc_x [mvna_pkg::VERTEX_COUNT];
    int                 acc_y [mvna_pkg::VERTEX_COUNT];
    int                 acc_z [mvna_pkg::VERTEX_COUNT];

    t_normal expected_normals [$];
    int      error_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bit-pair integer square root
    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a vector to q1.14 unit length; returns 0 for the zero vector
    function automatic bit unit_scale(input longint cx, input longint cy, input longint cz,
                                      output logic signed [15:0] nx,
                                      output logic signed [15:0] ny,
                                      output logic signed [15:0] nz);
        longint    c [3];
        bit [63:0] mag [3];
        bit [63:0] m, sq, len, q;
        int        s;
        logic signed [15:0] n [3];
        c[0] = cx; c[1] = cy; c[2] = cz;
        m = 0;
        sq = 0;
        s = 0;
        nx = 0; ny = 0; nz = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = c[k] < 0 ? -c[k] : c[k];
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) return 1'b0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> s;
            sq += mag[k] * mag[k];
        end
        len = int_sqrt(sq);
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            n[k] = c[k] < 0 ? -16'(q) : 16'(q);
        end
        nx = n[0]; ny = n[1]; nz = n[2];
        return 1'b1;
    endfunction

    function automatic int sat_acc(input int a, input int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 8388607) s = 8388607;
        if (s < -8388608) s = -8388608;
        return int'(s);
    endfunction

    // apply one accepted item to the predicted table, queue the normal a read returns
    task automatic update_normals(input t_item it);
        longint  d1 [3];
        longint  d2 [3];
        longint  cx, cy, cz;
        int      v [3];
        logic signed [15:0] nx, ny, nz;
        t_normal r;
        case (it.mode)
            mvna_pkg::MODE_LOAD: begin
                pos_x[it.vertex_index] = it.coord_x;
                pos_y[it.vertex_index] = it.coord_y;
                pos_z[it.vertex_index] = it.coord_z;
                acc_x[it.vertex_index] = 0;
                acc_y[it.vertex_index] = 0;
                acc_z[it.vertex_index] = 0;
            end
            mvna_pkg::MODE_TRI: begin
                v[0] = int'(it.corner_a); v[1] = int'(it.corner_b); v[2] = int'(it.corner_c);
                d1[0] = longint'(pos_x[v[2]]) - longint'(pos_x[v[1]]);
                d1[1] = longint'(pos_y[v[2]]) - longint'(pos_y[v[1]]);
                d1[2] = longint'(pos_z[v[2]]) - longint'(pos_z[v[1]]);
                d2[0] = longint'(pos_x[v[1]]) - longint'(pos_x[v[0]]);
                d2[1] = longint'(pos_y[v[1]]) - longint'(pos_y[v[0]]);
                d2[2] = longint'(pos_z[v[1]]) - longint'(pos_z[v[0]]);
                cx = d1[1] * d2[2] - d1[2] * d2[1];
                cy = d1[2] * d2[0] - d1[0] * d2[2];
                cz = d1[0] * d2[1] - d1[1] * d2[0];
                // degenerate face adds nothing
                if (unit_scale(cx, cy, cz, nx, ny, nz)) begin
                    for (int k = 0; k < 3; k++) begin
                        acc_x[v[k]] = sat_acc(acc_x[v[k]], int'(nx));
                        acc_y[v[k]] = sat_acc(acc_y[v[k]], int'(ny));
                        acc_z[v[k]] = sat_acc(acc_z[v[k]], int'(nz));
                    end
                end
            end
            mvna_pkg::MODE_READ: begin
                r.read_index = it.vertex_index;
                r.normal_undefined = !unit_scale(longint'(acc_x[it.vertex_index]),
                                                 longint'(acc_y[it.vertex_index]),
                                                 longint'(acc_z[it.vertex_index]),
                                                 nx, ny, nz);
                r.normal_x = nx;
                r.normal_y = ny;
                r.normal_z = nz;
                expected_normals.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    // drive one item from a falling edge, hold until the transfer, then idle at random
    task automatic send_item(input t_item it);
        in_ch.valid        = 1'b1;
        in_ch.mode         = it.mode;
        in_ch.vertex_index = it.vertex_index;
        in_ch.coord_x      = it.coord_x;
        in_ch.coord_y      = it.coord_y;
        in_ch.coord_z      = it.coord_z;
        in_ch.corner_a     = it.corner_a;
        in_ch.corner_b     = it.corner_b;
        in_ch.corner_c     = it.corner_c;
        do @(posedge i_clk); while (!in_ch.ready);
        update_normals(it);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
    endtask

    function automatic t_item make_item(input logic [1:0] mode, input int vi,
                                        input int x, input int y, input int z,
                                        input int a, input int b, input int c);
        t_item it;
        it.mode = mode;
        it.vertex_index = 6'(vi);
        it.coord_x = 16'(x); it.coord_y = 16'(y); it.coord_z = 16'(z);
        it.corner_a = 6'(a); it.corner_b = 6'(b); it.corner_c = 6'(c);
        return it;
    endfunction

    task automatic load(input int vi, input int x, input int y, input int z);
        send_item(make_item(mvna_pkg::MODE_LOAD, vi, x, y, z, $urandom, $urandom, $urandom));
    endtask

    task automatic triangle(input int a, input int b, input int c);
        send_item(make_item(mvna_pkg::MODE_TRI, $urandom, $urandom, $urandom, $urandom,
                            a, b, c));
    endtask

    task automatic read_normal(input int vi);
        send_item(make_item(mvna_pkg::MODE_READ, vi, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
    endtask

    // sender holds off until every pending normal has come back
    task automatic wait_results;
        while (expected_normals.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // every vertex gets a position before any triangle or read touches it
    task automatic test_table_fill;
        for (int v = 0; v < mvna_pkg::VERTEX_COUNT; v++)
            load(v, $urandom, $urandom, $urandom);
    endtask

    // field extremes, degenerate faces, zero sums and the spare mode
    task automatic test_directed;
        load(0, 32767, 32767, 32767);
        load(1, -32768, -32768, -32768);
        load(2, -32768, 32767, 0);
        load(3, 0, 0, 0);
        load(63, 32767, -32768, 1);
        triangle(0, 1, 2);
        triangle(2, 63, 3);
        triangle(4, 4, 5);                  // repeated corners
        load(6, 0, 0, 0);
        load(7, 100, 100, 100);
        load(8, 200, 200, 200);
        triangle(6, 7, 8);                  // collinear corners
        read_normal(0);
        read_normal(63);
        read_normal(6);                     // zero sum reads as undefined
        read_normal(9);
        send_item(make_item(MODE_SPARE, 0, 0, 0, 0, 0, 1, 2));
        triangle(63, 0, 1);
        read_normal(1);
        read_normal(2);
        wait_results();
    endtask

    // drive accumulators into both saturation limits
    task automatic test_saturation;
        load(10, 0, 0, 0);
        load(11, 16384, 0, 0);
        load(12, 0, 16384, 0);
        for (int k = 0; k < 520; k++) triangle(10, 11, 12);
        read_normal(10);
        triangle(10, 12, 11);
        read_normal(11);
        load(10, 0, 0, 0);
        load(11, 16384, 0, 0);
        load(12, 0, 16384, 0);
        for (int k = 0; k < 520; k++) triangle(12, 11, 10);
        read_normal(10);
        read_normal(12);
    endtask

    function automatic int rand_coord;
        if ($urandom_range(1)) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // random traffic: mostly triangles and reads, occasional reloads and spare mode
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int sel;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 15)
                load($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
            else if (sel < 65)
                triangle($urandom_range(63), $urandom_range(63), $urandom_range(63));
            else if (sel < 95)
                read_normal($urandom_range(63));
            else
                send_item(make_item(MODE_SPARE, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom));
        end
    endtask

    // receiver stalls at random, changed on the falling edge
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_normals.size() == 0) begin
                $display("unexpected normal for vertex %0d at cycle %0d",
                         out_ch.read_index, cycle_count);
                error_count++;
            end else begin
                e = expected_normals.pop_front();
                if (out_ch.read_index !== e.read_index)
                    report_mismatch("read_index", int'(out_ch.read_index),
                                    int'(e.read_index));
                if (out_ch.normal_x !== e.normal_x)
                    report_mismatch("normal_x", int'(out_ch.normal_x), int'(e.normal_x));
                if (out_ch.normal_y !== e.normal_y)
                    report_mismatch("normal_y", int'(out_ch.normal_y), int'(e.normal_y));
                if (out_ch.normal_z !== e.normal_z)
                    report_mismatch("normal_z", int'(out_ch.normal_z), int'(e.normal_z));
                if (out_ch.normal_undefined !== e.normal_undefined)
                    report_mismatch("normal_undefined", int'(out_ch.normal_undefined),
                                    int'(e.normal_undefined));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = mvna_pkg::MODE_LOAD;
        in_ch.vertex_index = 0;
        in_ch.coord_x  = 0;
        in_ch.coord_y  = 0;
        in_ch.coord_z  = 0;
        in_ch.corner_a = 0;
        in_ch.corner_b = 0;
        in_ch.corner_c = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_directed();
        test_saturation();
        test_random(170, 0, 0);
        test_random(170, 73, 0);
        wait_results();
        test_random(170, 0, 73);
        test_random(170, 26, 26);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_normals.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
